@@ rtl/core/unaligned_bam_stream_parser_assert.svh @@
// ----------------------------------------------------------------------------
// unaligned_bam_stream_parser_assert.svh
// Assertion macros used by the parser's port checker.
// ----------------------------------------------------------------------------
`ifndef UNALIGNED_BAM_STREAM_PARSER_ASSERT_SVH
`define UNALIGNED_BAM_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define UBSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubsp assertion failed");

// Next-cycle implication.
`define UBSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubsp assertion failed");

`endif

@@ rtl/core/ubsp_pkg.sv @@
// ----------------------------------------------------------------------------
// ubsp_pkg
// Types, codes and helpers of the unaligned BAM stream parser.
// ----------------------------------------------------------------------------
package ubsp_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_HLEN, PH_TEXT, PH_NREF, PH_RLNAME, PH_RNAME,
    PH_RLREF, PH_CORE, PH_PAYLOAD, PH_DONE, PH_ERROR
  } phase_t;

  localparam logic [2:0] KIND_NAME  = 3'd0;
  localparam logic [2:0] KIND_BASE  = 3'd1;
  localparam logic [2:0] KIND_QUAL  = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;
  localparam logic [2:0] KIND_ERROR = 3'd5;

  localparam logic [3:0] ERR_MAGIC_SHORT   = 4'd1;
  localparam logic [3:0] ERR_NOT_BAM       = 4'd2;
  localparam logic [3:0] ERR_HLEN_SHORT    = 4'd3;
  localparam logic [3:0] ERR_HLEN_NEG      = 4'd4;
  localparam logic [3:0] ERR_TEXT_SHORT    = 4'd5;
  localparam logic [3:0] ERR_NREF_SHORT    = 4'd6;
  localparam logic [3:0] ERR_NREF_NEG      = 4'd7;
  localparam logic [3:0] ERR_REFHDR_SHORT  = 4'd8;
  localparam logic [3:0] ERR_REFNAME_BAD   = 4'd9;
  localparam logic [3:0] ERR_REFENT_SHORT  = 4'd10;
  localparam logic [3:0] ERR_RECORD_SHORT  = 4'd11;
  localparam logic [3:0] ERR_CORRUPT       = 4'd12;
  localparam logic [3:0] ERR_PAYLOAD_SHORT = 4'd13;
  localparam logic [3:0] ERR_ALIGNED       = 4'd14;
  localparam logic [3:0] ERR_LAYOUT        = 4'd15;

  localparam logic [31:0] BAM_MAGIC    = 32'h014D_4142;
  localparam logic [31:0] CORE_MIN     = 32'd32;
  localparam logic [5:0]  CORE_LAST    = 6'd35;
  localparam logic [7:0]  QUAL_OFFSET  = 8'd33;
  localparam logic [7:0]  QUAL_ABSENT  = 8'hff;
  localparam logic [31:0] NO_COORD     = 32'hffff_ffff;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_char;
    logic [30:0] seq_length;
    logic        qual_ok;
    logic [3:0]  error_code;
    logic        out_last;
  } out_word_t;

  // Results of one accepted word, in order, from the parser to the queue.
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  res0;
    out_word_t  res1;
  } ubsp_step_t;

  function automatic out_word_t mk_res(logic [2:0] k, logic [7:0] ch, logic [30:0] len,
                                       logic q, logic [3:0] e);
    out_word_t r;
    r.kind       = k;
    r.out_char   = ch;
    r.seq_length = len;
    r.qual_ok    = q;
    r.error_code = e;
    r.out_last   = 1'b0;
    return r;
  endfunction

  // 4-bit base code to ASCII.
  function automatic logic [7:0] nt_decode(logic [3:0] code);
    logic [7:0] c;
    unique case (code)
      4'd1:    c = "A";
      4'd2:    c = "C";
      4'd4:    c = "G";
      4'd8:    c = "T";
      default: c = "N";
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/ubsp_core.sv @@
// ----------------------------------------------------------------------------
// ubsp_core
// Parser state and per-word result generation (up to two results a word).
// ----------------------------------------------------------------------------
module ubsp_core import ubsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  in_word_t   din,
  output ubsp_step_t step
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] bc_r, bc_nxt;
  logic [31:0] wa_r, wa_nxt;
  logic [30:0] refs_r, refs_nxt;
  logic [31:0] plen_r, plen_nxt;
  logic [7:0]  nlen_r, nlen_nxt;
  logic [15:0] cigar_r, cigar_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic [31:0] refi_r, refi_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [30:0] nbase_r, nbase_nxt;
  logic        qgood_r, qgood_nxt;
  logic        rbad_r, rbad_nxt;
  logic [3:0]  err_r, err_nxt;
  // region bounds inside the payload, built while the core streams in
  logic [18:0] ss_r, ss_nxt;
  logic [31:0] hs_r, hs_nxt;
  logic [31:0] qs_r, qs_nxt;
  logic [32:0] qe_r, qe_nxt;

  logic        e0_v, e1_v, t_v;
  out_word_t   e0, e1, t;
  logic [7:0]  b;
  logic [31:0] wa_ins;
  logic        wdone;
  logic        aligned;
  logic        bad_new;
  logic        fin;
  logic        fin_bad;
  logic [30:0] fin_nbase;
  logic [31:0] blk_rem;
  logic [32:0] off1;
  logic [5:0]  c6;
  logic [31:0] pl_b, ri_b, po_b, wa_b;
  logic [7:0]  nl_b;
  logic [15:0] cg_b, fl_b;

  always_comb begin
    phase_nxt = phase_r; bc_nxt = bc_r; wa_nxt = wa_r; refs_nxt = refs_r;
    plen_nxt = plen_r; nlen_nxt = nlen_r; cigar_nxt = cigar_r; flags_nxt = flags_r;
    refi_nxt = refi_r; pos_nxt = pos_r; nbase_nxt = nbase_r; qgood_nxt = qgood_r;
    rbad_nxt = rbad_r; err_nxt = err_r;
    ss_nxt = ss_r; hs_nxt = hs_r; qs_nxt = qs_r; qe_nxt = qe_r;
    e0_v = 1'b0; e1_v = 1'b0; t_v = 1'b0;
    e0 = '0; e1 = '0; t = '0;
    fin = 1'b0; fin_bad = 1'b0; fin_nbase = nbase_r;
    b = din.in_byte;
    wa_ins = wa_r | ({24'd0, b} << {bc_r[1:0], 3'b000});
    wdone = (bc_r[1:0] == 2'd3);
    aligned = !flags_r[2] || (refi_r != NO_COORD) || (pos_r != NO_COORD) ||
              (cigar_r != 16'd0);
    blk_rem = plen_r - CORE_MIN;
    bad_new = 1'b0;
    off1 = {1'b0, bc_r} + 33'd1;
    c6 = bc_r[5:0];
    pl_b = (bc_r == 32'd0) ? 32'd0 : plen_r;
    ri_b = (bc_r == 32'd0) ? 32'd0 : refi_r;
    po_b = (bc_r == 32'd0) ? 32'd0 : pos_r;
    wa_b = (bc_r == 32'd0) ? 32'd0 : wa_r;
    nl_b = (bc_r == 32'd0) ? 8'd0 : nlen_r;
    cg_b = (bc_r == 32'd0) ? 16'd0 : cigar_r;
    fl_b = (bc_r == 32'd0) ? 16'd0 : flags_r;

    if (phase_r == PH_ERROR) begin
      t_v = 1'b1; t = mk_res(KIND_ERROR, 8'd0, 31'd0, 1'b0, err_r);
    end else if (phase_r == PH_DONE) begin
      t_v = 1'b1; t = mk_res(KIND_END, 8'd0, 31'd0, 1'b0, 4'd0);
    end else if (din.end_of_stream) begin
      t_v = 1'b1;
      phase_nxt = PH_ERROR;
      unique case (phase_r)
        PH_MAGIC:           err_nxt = ERR_MAGIC_SHORT;
        PH_HLEN:            err_nxt = ERR_HLEN_SHORT;
        PH_TEXT:            err_nxt = ERR_TEXT_SHORT;
        PH_NREF:            err_nxt = ERR_NREF_SHORT;
        PH_RLNAME:          err_nxt = ERR_REFHDR_SHORT;
        PH_RNAME, PH_RLREF: err_nxt = ERR_REFENT_SHORT;
        PH_CORE:            err_nxt = ERR_RECORD_SHORT;
        default:            err_nxt = ERR_PAYLOAD_SHORT;
      endcase
      if (phase_r == PH_CORE && bc_r == 32'd0) begin
        phase_nxt = PH_DONE;
        err_nxt = err_r;
        t = mk_res(KIND_END, 8'd0, 31'd0, 1'b0, 4'd0);
      end else begin
        t = mk_res(KIND_ERROR, 8'd0, 31'd0, 1'b0, err_nxt);
      end
    end else begin
      unique case (phase_r)
        PH_MAGIC, PH_HLEN, PH_NREF, PH_RLNAME, PH_RLREF: begin
          bc_nxt = bc_r + 32'd1;
          wa_nxt = wa_ins;
          if (wdone) begin
            bc_nxt = 32'd0;
            wa_nxt = 32'd0;
            unique case (phase_r)
              PH_MAGIC: begin
                if (wa_ins != BAM_MAGIC) begin
                  t_v = 1'b1; err_nxt = ERR_NOT_BAM; phase_nxt = PH_ERROR;
                end else begin
                  phase_nxt = PH_HLEN;
                end
              end
              PH_HLEN: begin
                if (wa_ins[31]) begin
                  t_v = 1'b1; err_nxt = ERR_HLEN_NEG; phase_nxt = PH_ERROR;
                end else if (wa_ins == 32'd0) begin
                  phase_nxt = PH_NREF;
                end else begin
                  bc_nxt = wa_ins; phase_nxt = PH_TEXT;
                end
              end
              PH_NREF: begin
                if (wa_ins[31]) begin
                  t_v = 1'b1; err_nxt = ERR_NREF_NEG; phase_nxt = PH_ERROR;
                end else if (wa_ins == 32'd0) begin
                  phase_nxt = PH_CORE;
                end else begin
                  refs_nxt = wa_ins[30:0]; phase_nxt = PH_RLNAME;
                end
              end
              PH_RLNAME: begin
                if (wa_ins == 32'd0 || wa_ins[31]) begin
                  t_v = 1'b1; err_nxt = ERR_REFNAME_BAD; phase_nxt = PH_ERROR;
                end else begin
                  bc_nxt = wa_ins; phase_nxt = PH_RNAME;
                end
              end
              default: begin
                refs_nxt = refs_r - 31'd1;
                phase_nxt = (refs_r == 31'd1) ? PH_CORE : PH_RLNAME;
              end
            endcase
            t = mk_res(KIND_ERROR, 8'd0, 31'd0, 1'b0, err_nxt);
          end
        end
        PH_TEXT, PH_RNAME: begin
          bc_nxt = bc_r - 32'd1;
          if (bc_r == 32'd1) begin
            phase_nxt = (phase_r == PH_TEXT) ? PH_NREF : PH_RLREF;
          end
        end
        PH_CORE: begin
          plen_nxt = pl_b; refi_nxt = ri_b; pos_nxt = po_b; wa_nxt = wa_b;
          nlen_nxt = nl_b; cigar_nxt = cg_b; flags_nxt = fl_b;
          if (c6 < 6'd4) begin
            plen_nxt = pl_b | ({24'd0, b} << {bc_r[1:0], 3'b000});
          end else if (c6 < 6'd8) begin
            refi_nxt = ri_b | ({24'd0, b} << {bc_r[1:0], 3'b000});
          end else if (c6 < 6'd12) begin
            pos_nxt = po_b | ({24'd0, b} << {bc_r[1:0], 3'b000});
          end else if (c6 == 6'd12) begin
            nlen_nxt = b;
          end else if (c6 == 6'd16 || c6 == 6'd17) begin
            cigar_nxt = cg_b | ({8'd0, b} << {bc_r[0], 3'b000});
          end else if (c6 == 6'd18 || c6 == 6'd19) begin
            flags_nxt = fl_b | ({8'd0, b} << {bc_r[0], 3'b000});
          end else if (c6 >= 6'd20 && c6 < 6'd24) begin
            wa_nxt = wa_b | ({24'd0, b} << {bc_r[1:0], 3'b000});
          end
          // staged bound arithmetic at core bytes 18, 24 and 25
          if (c6 == 6'd18) ss_nxt = {11'd0, nlen_r} + {1'b0, cigar_r, 2'b00};
          if (c6 == 6'd24) begin
            hs_nxt = {13'd0, ss_r} + {2'd0, wa_r[30:1]};
            qs_nxt = {13'd0, ss_r} + ({1'b0, wa_r[30:0]} + 32'd1 >> 1);
          end
          if (c6 == 6'd25) qe_nxt = {1'b0, qs_r} + {2'd0, wa_r[30:0]};
          bc_nxt = bc_r + 32'd1;
          if (c6 == CORE_LAST) begin
            bc_nxt = 32'd0;
            if (plen_r[31] || plen_r < CORE_MIN || wa_r[31]) begin
              t_v = 1'b1; err_nxt = ERR_CORRUPT; phase_nxt = PH_ERROR;
              t = mk_res(KIND_ERROR, 8'd0, 31'd0, 1'b0, ERR_CORRUPT);
            end else begin
              nbase_nxt = wa_r[30:0];
              wa_nxt = 32'd0;
              plen_nxt = blk_rem;
              qgood_nxt = 1'b1;
              bad_new = aligned || ({1'b0, blk_rem} < qe_r);
              rbad_nxt = bad_new;
              if (blk_rem == 32'd0) begin
                fin = 1'b1; fin_bad = bad_new; fin_nbase = wa_r[30:0];
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
        end
        default: begin
          if (!rbad_r) begin
            if (nlen_r != 8'd0 && off1 < {25'd0, nlen_r}) begin
              e0_v = 1'b1; e0 = mk_res(KIND_NAME, b, 31'd0, 1'b0, 4'd0);
            end else if (bc_r >= {13'd0, ss_r} && bc_r < qs_r) begin
              e0_v = 1'b1; e0 = mk_res(KIND_BASE, nt_decode(b[7:4]), 31'd0, 1'b0, 4'd0);
              if (bc_r < hs_r) begin
                e1_v = 1'b1; e1 = mk_res(KIND_BASE, nt_decode(b[3:0]), 31'd0, 1'b0, 4'd0);
              end
            end else if (bc_r >= qs_r && {1'b0, bc_r} < qe_r) begin
              if (qgood_r) begin
                if (b == QUAL_ABSENT) begin
                  qgood_nxt = 1'b0;
                end else begin
                  e0_v = 1'b1; e0 = mk_res(KIND_QUAL, b + QUAL_OFFSET, 31'd0, 1'b0, 4'd0);
                end
              end
            end
          end
          bc_nxt = off1[31:0];
          if (off1 >= {1'b0, plen_r}) begin
            fin = 1'b1; fin_bad = rbad_r; fin_nbase = nbase_r;
          end
        end
      endcase
    end

    // end of record: done item or the deferred record error
    if (fin) begin
      bc_nxt = 32'd0;
      t_v = 1'b1;
      if (fin_bad) begin
        err_nxt = aligned ? ERR_ALIGNED : ERR_LAYOUT;
        phase_nxt = PH_ERROR;
        t = mk_res(KIND_ERROR, 8'd0, 31'd0, 1'b0, err_nxt);
      end else begin
        phase_nxt = PH_CORE;
        t = mk_res(KIND_DONE, 8'd0, fin_nbase, qgood_nxt, 4'd0);
      end
    end

    // pack in order: chars first, then the terminal item
    step = '0;
    step.cnt = {1'b0, e0_v} + {1'b0, e1_v} + {1'b0, t_v};
    step.res0 = e0_v ? e0 : t;
    step.res1 = e1_v ? e1 : t;
    if (step.cnt == 2'd1) step.res0.out_last = 1'b1;
    if (step.cnt == 2'd2) step.res1.out_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC; bc_r <= '0; wa_r <= '0; refs_r <= '0; plen_r <= '0;
      nlen_r <= '0; cigar_r <= '0; flags_r <= '0; refi_r <= '0; pos_r <= '0;
      nbase_r <= '0; qgood_r <= 1'b1; rbad_r <= 1'b0; err_r <= '0;
    end else if (take) begin
      phase_r <= phase_nxt; bc_r <= bc_nxt; wa_r <= wa_nxt; refs_r <= refs_nxt;
      plen_r <= plen_nxt; nlen_r <= nlen_nxt; cigar_r <= cigar_nxt;
      flags_r <= flags_nxt; refi_r <= refi_nxt; pos_r <= pos_nxt;
      nbase_r <= nbase_nxt; qgood_r <= qgood_nxt; rbad_r <= rbad_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ss_r <= ss_nxt; hs_r <= hs_nxt; qs_r <= qs_nxt; qe_r <= qe_nxt;
    end
  end

endmodule

@@ rtl/core/unaligned_bam_stream_parser.sv @@
// ----------------------------------------------------------------------------
// unaligned_bam_stream_parser
// Header skip, record core checks and name/base/quality extraction.
// ----------------------------------------------------------------------------
// Each accepted byte's results are written to a queue and leave on out_* in order.
// Throughput: one byte per cycle unless in_stall; a byte with two results
//   gives two words, one at a time on out_*, from a 4-entry queue.
// in_stall rises when the queue holds more than two words.
// Reset (rst_n low, synchronous): parser back to the magic phase, queue empty.
module unaligned_bam_stream_parser import ubsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  ubsp_step_t step;
  logic       take;
  logic       pop;

  // result queue: each byte pushes up to two words
  out_word_t  q_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] push_n;

  // room for two words always kept before a byte is taken
  assign in_stall  = (cnt_r > 3'd2);
  assign take      = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q_r[rd_ptr_r];

  ubsp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .din   (in_data),
    .step  (step)
  );

  always_comb begin
    push_n     = take ? step.cnt : 2'd0;
    wr_ptr_nxt = wr_ptr_r + push_n;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    cnt_nxt    = cnt_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_ptr_r] <= step.res0;
    if (push_n == 2'd2) q_r[wr_ptr_r + 2'd1] <= step.res1;
  end

endmodule

@@ rtl/core/ubsp_checker.sv @@
// ----------------------------------------------------------------------------
// ubsp_port_checker
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
`include "unaligned_bam_stream_parser_assert.svh"

module ubsp_port_checker import ubsp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  logic out_err;
  logic out_done;

  assign out_err  = out_valid && (out_data.kind == KIND_ERROR);
  assign out_done = out_valid && (out_data.kind == KIND_DONE);

  `UBSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `UBSP_ASSERT_NOW(a_err_code, out_err, out_data.error_code != 4'd0)
  `UBSP_ASSERT_NOW(a_done_nochar, out_done, out_data.out_char == 8'd0)
  `UBSP_ASSERT_NEXT(a_err_sticky, out_err && !out_stall, !out_valid || out_err)

endmodule

bind unaligned_bam_stream_parser ubsp_port_checker u_ubsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ sim/ubsp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubsp_checker
// Watches both channels of the BAM stream parser, predicts the result words
// of every accepted byte and compares them in order as they leave.
// ----------------------------------------------------------------------------
module ubsp_checker import ubsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        fail_count,
  output int        words_pending
);

  phase_t      ph;
  logic [31:0] cnt, asm_w, plen, ref_id, map_pos;
  logic [30:0] refs, bases;
  logic [7:0]  nlen;
  logic [15:0] ncig, flags;
  logic        qgood, rbad;
  logic [3:0]  sticky;

  out_word_t parsed_words[$];
  out_word_t step_words[$];

  function automatic logic [7:0] base_char(logic [3:0] code);
    case (code)
      4'd1:    return "A";
      4'd2:    return "C";
      4'd4:    return "G";
      4'd8:    return "T";
      default: return "N";
    endcase
  endfunction

  function automatic void push_word(logic [2:0] k, logic [7:0] ch, logic [30:0] len,
                                    logic q, logic [3:0] e);
    out_word_t w;
    w.kind = k; w.out_char = ch; w.seq_length = len;
    w.qual_ok = q; w.error_code = e; w.out_last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void raise_err(logic [3:0] code);
    sticky = code;
    ph = PH_ERROR;
    push_word(KIND_ERROR, 8'd0, 31'd0, 1'b0, code);
  endfunction

  // little-endian word collection; returns 1 on the fourth byte
  function automatic bit take_le(logic [7:0] b, output logic [31:0] v);
    asm_w = asm_w | (32'(b) << (8 * cnt[1:0]));
    cnt = cnt + 1;
    v = asm_w;
    if (cnt >= 4) begin
      asm_w = '0;
      cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit rec_aligned();
    return !flags[2] || ref_id != NO_COORD || map_pos != NO_COORD || ncig != 0;
  endfunction

  function automatic longint seq_off();
    return longint'(nlen) + (longint'(ncig) << 2);
  endfunction

  function automatic longint qual_begin();
    return seq_off() + ((longint'(bases) + 1) >> 1);
  endfunction

  function automatic void close_record();
    cnt = '0;
    if (rbad) begin
      raise_err(rec_aligned() ? ERR_ALIGNED : ERR_LAYOUT);
      return;
    end
    push_word(KIND_DONE, 8'd0, bases, qgood, 4'd0);
    ph = PH_CORE;
  endfunction

  function automatic void core_done();
    logic [31:0] blk;
    blk = plen;
    cnt = '0;
    if (blk[31] || blk < CORE_MIN || asm_w[31]) begin
      raise_err(ERR_CORRUPT);
      return;
    end
    bases = asm_w[30:0];
    asm_w = '0;
    plen = blk - CORE_MIN;
    qgood = 1'b1;
    if (rec_aligned()) rbad = 1'b1;
    else rbad = longint'(plen) < qual_begin() + longint'(bases);
    if (plen == 0) close_record();
    else ph = PH_PAYLOAD;
  endfunction

  function automatic void core_byte(logic [7:0] b);
    logic [31:0] c;
    c = cnt;
    if (c == 0) begin
      plen = '0; ref_id = '0; map_pos = '0; nlen = '0; ncig = '0; flags = '0; asm_w = '0;
    end
    if (c < 4) plen |= 32'(b) << (8 * c);
    else if (c < 8) ref_id |= 32'(b) << (8 * (c - 4));
    else if (c < 12) map_pos |= 32'(b) << (8 * (c - 8));
    else if (c == 12) nlen = b;
    else if (c == 16 || c == 17) ncig |= 16'(b) << (8 * (c - 16));
    else if (c == 18 || c == 19) flags |= 16'(b) << (8 * (c - 18));
    else if (c >= 20 && c < 24) asm_w |= 32'(b) << (8 * (c - 20));
    cnt = c + 1;
    if (c >= 35) core_done();
  endfunction

  function automatic void payload_byte(logic [7:0] b);
    longint off, ss, qs;
    off = longint'(cnt);
    if (!rbad) begin
      ss = seq_off();
      qs = qual_begin();
      if (nlen != 0 && off + 1 < longint'(nlen)) begin
        push_word(KIND_NAME, b, 31'd0, 1'b0, 4'd0);
      end else if (off >= ss && off < qs) begin
        push_word(KIND_BASE, base_char(b[7:4]), 31'd0, 1'b0, 4'd0);
        if (((off - ss) << 1) + 1 < longint'(bases))
          push_word(KIND_BASE, base_char(b[3:0]), 31'd0, 1'b0, 4'd0);
      end else if (off >= qs && off < qs + longint'(bases)) begin
        if (qgood) begin
          if (b == QUAL_ABSENT) qgood = 1'b0;
          else push_word(KIND_QUAL, b + QUAL_OFFSET, 31'd0, 1'b0, 4'd0);
        end
      end
    end
    cnt = cnt + 1;
    if (cnt >= plen) close_record();
  endfunction

  // one accepted input word -> its result words appended to parsed_words
  function automatic void parse_word(in_word_t w);
    logic [31:0] v;
    logic [7:0]  b;
    b = w.in_byte;
    step_words.delete();
    if (sticky != 0 || ph == PH_ERROR) begin
      push_word(KIND_ERROR, 8'd0, 31'd0, 1'b0, sticky);
    end else if (ph == PH_DONE) begin
      push_word(KIND_END, 8'd0, 31'd0, 1'b0, 4'd0);
    end else if (w.end_of_stream) begin
      case (ph)
        PH_MAGIC:           raise_err(ERR_MAGIC_SHORT);
        PH_HLEN:            raise_err(ERR_HLEN_SHORT);
        PH_TEXT:            raise_err(ERR_TEXT_SHORT);
        PH_NREF:            raise_err(ERR_NREF_SHORT);
        PH_RLNAME:          raise_err(ERR_REFHDR_SHORT);
        PH_RNAME, PH_RLREF: raise_err(ERR_REFENT_SHORT);
        PH_CORE: begin
          if (cnt == 0) begin
            ph = PH_DONE;
            push_word(KIND_END, 8'd0, 31'd0, 1'b0, 4'd0);
          end else begin
            raise_err(ERR_RECORD_SHORT);
          end
        end
        default:            raise_err(ERR_PAYLOAD_SHORT);
      endcase
    end else begin
      case (ph)
        PH_MAGIC: if (take_le(b, v)) begin
          if (v != BAM_MAGIC) raise_err(ERR_NOT_BAM);
          else ph = PH_HLEN;
        end
        PH_HLEN: if (take_le(b, v)) begin
          if (v[31]) raise_err(ERR_HLEN_NEG);
          else if (v == 0) ph = PH_NREF;
          else begin cnt = v; ph = PH_TEXT; end
        end
        PH_TEXT: begin
          cnt = cnt - 1;
          if (cnt == 0) ph = PH_NREF;
        end
        PH_NREF: if (take_le(b, v)) begin
          if (v[31]) raise_err(ERR_NREF_NEG);
          else if (v == 0) ph = PH_CORE;
          else begin refs = v[30:0]; ph = PH_RLNAME; end
        end
        PH_RLNAME: if (take_le(b, v)) begin
          if (v == 0 || v[31]) raise_err(ERR_REFNAME_BAD);
          else begin cnt = v; ph = PH_RNAME; end
        end
        PH_RNAME: begin
          cnt = cnt - 1;
          if (cnt == 0) ph = PH_RLREF;
        end
        PH_RLREF: if (take_le(b, v)) begin
          refs = refs - 1;
          ph = (refs == 0) ? PH_CORE : PH_RLNAME;
        end
        PH_CORE: core_byte(b);
        default: payload_byte(b);
      endcase
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].out_last = 1'b1;
    foreach (step_words[i]) parsed_words.push_back(step_words[i]);
  endfunction

  always @(posedge clk) begin
    out_word_t exp_w;
    logic      bad;
    if (!rst_n) begin
      ph = PH_MAGIC;
      cnt = '0; asm_w = '0; refs = '0; plen = '0; nlen = '0; ncig = '0;
      flags = '0; ref_id = '0; map_pos = '0; bases = '0;
      qgood = 1'b1; rbad = 1'b0; sticky = '0;
      parsed_words.delete();
      fail_count <= 0;
      words_pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parsed_words.size() == 0) begin
          $error("unexpected result word: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = parsed_words.pop_front();
          bad = 1'b0;
          if (out_data.kind !== exp_w.kind) begin
            $error("kind: expected %0d, got %0d", exp_w.kind, out_data.kind); bad = 1'b1;
          end
          if (out_data.out_char !== exp_w.out_char) begin
            $error("out_char: expected %0h, got %0h", exp_w.out_char, out_data.out_char);
            bad = 1'b1;
          end
          if (out_data.seq_length !== exp_w.seq_length) begin
            $error("seq_length: expected %0d, got %0d", exp_w.seq_length,
                   out_data.seq_length);
            bad = 1'b1;
          end
          if (out_data.qual_ok !== exp_w.qual_ok) begin
            $error("qual_ok: expected %0b, got %0b", exp_w.qual_ok, out_data.qual_ok);
            bad = 1'b1;
          end
          if (out_data.error_code !== exp_w.error_code) begin
            $error("error_code: expected %0d, got %0d", exp_w.error_code,
                   out_data.error_code);
            bad = 1'b1;
          end
          if (out_data.out_last !== exp_w.out_last) begin
            $error("out_last: expected %0b, got %0b", exp_w.out_last, out_data.out_last);
            bad = 1'b1;
          end
          if (bad) fail_count <= fail_count + 1;
        end
      end
      // expectations of an accepted byte are queued after this edge's output check
      if (in_valid && !in_stall) parse_word(in_data);
      words_pending <= parsed_words.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the BAM stream parser one stream: a bad magic, a cut header, or a header
// with references, random unaligned records, then one of several endings.
// ----------------------------------------------------------------------------
module tb_top import ubsp_pkg::*; ();

  localparam int STALL_LIMIT = 2000;   // cycles with no word moving
  localparam int TARGET      = 550;    // stream bytes before the ending

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  int fail_count;
  int words_pending;
  int words_sent;
  int tx_idle_pct;     // sender gap rate, percent
  int rx_stall_pct;    // receiver stall rate, percent
  int quiet_cycles;

  unaligned_bam_stream_parser i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  ubsp_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .words_pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Idle profile follows the stream position: receiver-heavy stalls first,
  // then sender-heavy gaps, then a clean stretch at full rate.
  function automatic void set_pressure();
    if (words_sent < TARGET / 3) begin
      tx_idle_pct = 33; rx_stall_pct = 45;
    end else if (words_sent < 2 * TARGET / 3) begin
      tx_idle_pct = 45; rx_stall_pct = 33;
    end else begin
      tx_idle_pct = 0; rx_stall_pct = 0;
    end
  endfunction

  // One word on the input channel; called right after a rising edge.
  // Stall is sampled on the falling edge, where it is settled.
  task automatic put_word(logic [7:0] b, logic eos);
    set_pressure();
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.in_byte <= b;
    in_data.end_of_stream <= eos;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    words_sent++;
  endtask

  task automatic put_byte(logic [7:0] b);
    put_word(b, 1'b0);
  endtask

  // end of stream carries a random don't-care byte
  task automatic put_eos();
    put_word(8'($urandom), 1'b1);
  endtask

  task automatic put_le32(logic [31:0] v);
    for (int i = 0; i < 4; i++) put_byte(v[8 * i +: 8]);
  endtask

  // Record flavors
  typedef enum int { REC_GOOD, REC_ALIGNED, REC_LAYOUT, REC_CORRUPT } rec_kind_t;

  // Sends one record; cut >= 0 ends the stream after that many bytes.
  // directed: every nibble code in the sequence, quality extremes, 0xff last.
  task automatic put_record(rec_kind_t rk, int nl, int sl, int aux, bit directed, int cut);
    logic [7:0]  rec[$];
    logic [31:0] blk, refv, posv, lseq;
    logic [15:0] ncig, flg;
    int          sb, body;
    sb = (sl + 1) / 2;
    body = nl + sb + sl + aux;
    refv = NO_COORD;
    posv = NO_COORD;
    ncig = 16'd0;
    flg = 16'($urandom) | 16'h0004;
    lseq = 32'(sl);
    case (rk)
      REC_ALIGNED: case ($urandom_range(0, 3))
        0:       flg[2] = 1'b0;
        1:       refv = $urandom_range(0, 1000);
        2:       posv = $urandom;
        default: ncig = 16'($urandom_range(1, 3));
      endcase
      REC_LAYOUT:  body = $urandom_range(1, nl + sb + sl - 1);
      REC_CORRUPT: if ($urandom_range(0, 1)) lseq[31] = 1'b1;
      default: ;
    endcase
    blk = 32'(body) + CORE_MIN;
    if (rk == REC_CORRUPT && !lseq[31])
      blk = $urandom_range(0, 1) ? 32'($urandom_range(0, 31)) : ($urandom | 32'h8000_0000);
    for (int i = 0; i < 4; i++) rec.push_back(blk[8 * i +: 8]);
    for (int i = 0; i < 4; i++) rec.push_back(refv[8 * i +: 8]);
    for (int i = 0; i < 4; i++) rec.push_back(posv[8 * i +: 8]);
    rec.push_back(8'(nl));
    for (int i = 0; i < 3; i++) rec.push_back(8'($urandom));   // mapq, bin
    rec.push_back(ncig[7:0]); rec.push_back(ncig[15:8]);
    rec.push_back(flg[7:0]);  rec.push_back(flg[15:8]);
    for (int i = 0; i < 4; i++) rec.push_back(lseq[8 * i +: 8]);
    for (int i = 0; i < 12; i++) rec.push_back(8'($urandom));  // mate fields, tlen
    // payload body only makes sense for sane core sizes
    if (rk != REC_CORRUPT) begin
      for (int i = 0; i < body; i++) begin
        int  o;
        logic [7:0] v;
        o = i - nl - sb;
        v = 8'($urandom);
        if (directed && i >= nl && o < 0) v = {4'(2 * (i - nl)), 4'(2 * (i - nl) + 1)};
        else if (o >= 0 && o < sl) begin
          if (directed) v = (o == sl - 1) ? QUAL_ABSENT : (o == 0 ? 8'h00 : 8'hfe);
          else if ($urandom_range(0, 19) == 0) v = QUAL_ABSENT;
          else v = 8'($urandom_range(0, 60));
        end
        rec.push_back(v);
      end
    end
    foreach (rec[i]) begin
      if (cut >= 0 && i >= cut) break;
      put_byte(rec[i]);
    end
    if (cut >= 0) put_eos();
  endtask

  initial begin
    int nrefs, ending, ltext;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    words_sent = 0;
    tx_idle_pct = 33;
    rx_stall_pct = 45;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    ending = $urandom_range(0, 11);
    if (ending == 0) begin
      // broken magic: not a BAM stream at all
      put_le32(BAM_MAGIC ^ (32'd1 << $urandom_range(0, 31)));
    end else if (ending == 1) begin
      // stream ends somewhere inside the header
      put_byte("B");
      put_byte("A");
      if ($urandom_range(0, 1)) begin
        put_byte("M"); put_byte(8'd1);
        put_le32($urandom_range(0, 1) ? 32'd3 : 32'h8000_0000);
        put_byte(8'h00);
      end
      put_eos();
    end else begin
      // Directed header: text with byte extremes, references
      put_le32(BAM_MAGIC);
      ltext = 4;
      put_le32(ltext);
      put_byte(8'h00); put_byte(8'hff); put_byte(8'h55); put_byte(8'haa);
      nrefs = $urandom_range(1, 3);
      put_le32(nrefs);
      for (int r = 0; r < nrefs; r++) begin
        int ln;
        ln = $urandom_range(1, 4);
        put_le32(ln);
        repeat (ln) put_byte(8'($urandom));
        put_le32($urandom);
      end
      // Directed records: every base code, empty name, one-char name, no bases
      put_record(REC_GOOD, 5, 16, 1, 1'b1, -1);
      put_record(REC_GOOD, 0, 0, 0, 1'b0, -1);
      put_record(REC_GOOD, 1, 1, 2, 1'b0, -1);
      // Random well-formed records
      while (words_sent < TARGET)
        put_record(REC_GOOD, $urandom_range(0, 8), $urandom_range(0, 10),
                   $urandom_range(0, 3), 1'b0, -1);
      case (ending)
        2, 3, 4: put_eos();                                           // clean end
        5:  put_record(REC_GOOD, 4, 6, 1, 1'b0, $urandom_range(37, 50)); // truncated, or whole at 50
        6:  put_record(REC_GOOD, 3, 4, 0, 1'b0, $urandom_range(1, 35));  // mid-core
        7, 8: put_record(REC_ALIGNED, $urandom_range(0, 5), $urandom_range(0, 6), 1,
                         1'b0, -1);
        9:  put_record(REC_LAYOUT, $urandom_range(1, 5), $urandom_range(2, 8), 0, 1'b0, -1);
        10: put_record(REC_CORRUPT, 2, 2, 0, 1'b0, -1);
        default: put_record(REC_ALIGNED, 2, 3, 0, 1'b0, 40);          // bad, cut short
      endcase
    end
    // words after the stream ended or failed repeat the final outcome;
    // short early endings are padded up to the usual stream length
    repeat (3) put_word(8'($urandom), 1'($urandom));
    while (words_sent < TARGET) put_word(8'($urandom), 1'($urandom));
    in_valid <= 1'b0;

    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
